>>> rtl/lpcp_pkg.sv
// ----------------------------------------------------------------------------
// lpcp_pkg: shared types and constants of the lidar point projector
// Field widths, status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package lpcp_pkg;

    localparam int EXT_COEF_W  = 16;
    localparam int INT_COEF_W  = 21;
    localparam int PIX_W       = 16;
    localparam int DEPTH_W     = 20;
    localparam int HUE_W       = 8;
    localparam int UV_QUO_W    = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int M_TDATA_W   = 64;
    localparam int DEFF_W      = 33;
    localparam int HUE_NUM_W   = 42;
    localparam int HUE_DEN_W   = 33;
    localparam int HUE_MAX     = 240;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_INSIDE     = 2'd0;
    localparam status_t STATUS_BEHIND     = 2'd1;
    localparam status_t STATUS_ZERO_SCALE = 2'd2;
    localparam status_t STATUS_OUTSIDE    = 2'd3;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_EXT_ROW_X   = 3'd0;
    localparam cfg_index_t CFG_EXT_ROW_Y   = 3'd1;
    localparam cfg_index_t CFG_EXT_ROW_Z   = 3'd2;
    localparam cfg_index_t CFG_INT_ROW_U   = 3'd3;
    localparam cfg_index_t CFG_INT_ROW_V   = 3'd4;
    localparam cfg_index_t CFG_INT_ROW_W   = 3'd5;
    localparam cfg_index_t CFG_DEPTH_RANGE = 3'd6;
    localparam cfg_index_t CFG_IMAGE_SIZE  = 3'd7;

    localparam logic [63:0] EXT_ROW_X_RST   = 64'h0000_4000_0000_0000;
    localparam logic [63:0] EXT_ROW_Y_RST   = 64'h0000_0000_4000_0000;
    localparam logic [63:0] EXT_ROW_Z_RST   = 64'h0000_0000_0000_4000;
    localparam logic [63:0] INT_ROW_U_RST   = 64'h0;
    localparam logic [63:0] INT_ROW_V_RST   = 64'h0;
    localparam logic [63:0] INT_ROW_W_RST   = 64'h0000_0000_0000_0040;
    localparam logic [63:0] DEPTH_RANGE_RST = 64'h0000_01F4_0000_01F4;
    localparam logic [31:0] IMAGE_SIZE_RST  = 32'h01E0_0280;

    localparam logic [PIX_W-1:0]   PIX_MAX   = 16'h7FFF;
    localparam logic [PIX_W-1:0]   PIX_MIN   = 16'h8000;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 20'hF_FFFF;
    localparam logic [DEFF_W-1:0]  DEFF_BIG  = 33'h1_0000_0000;

    typedef struct packed {
        logic behind;
        logic zero_scale;
        logic neg_u;
        logic neg_v;
        logic ovf_u;
        logic ovf_v;
    } uv_flags_t;

    typedef struct packed {
        uv_flags_t             flags;
        logic [UV_QUO_W-1:0]   mag_u;
        logic [UV_QUO_W-1:0]   mag_v;
    } uv_res_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               degenerate;
    } hue_side_t;

endpackage

>>> rtl/lpcp_delay.sv
// ----------------------------------------------------------------------------
// lpcp_delay: enabled shift line
// Carries side data alongside the arithmetic cell chains.
// ----------------------------------------------------------------------------
module lpcp_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

>>> rtl/lpcp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// lpcp_sqrt_cell: one root bit of an integer square root
// Takes two radicand bits, decides one root bit, hands all on registered.
// ----------------------------------------------------------------------------
module lpcp_sqrt_cell #(
    parameter int R_W = 26
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [2*R_W-1:0]   rad_in,
    input  logic [R_W+2:0]     rem_in,
    input  logic [R_W-1:0]     root_in,
    output logic [2*R_W-1:0]   rad_out,
    output logic [R_W+2:0]     rem_out,
    output logic [R_W-1:0]     root_out
);

    localparam int RAD_W = 2 * R_W;
    localparam int REM_W = R_W + 3;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;
    logic [REM_W-1:0] rem_next;
    logic [R_W-1:0]   root_next;
    logic [RAD_W-1:0] rad_next;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [R_W-1:0]   root_reg;

    // remainder never exceeds twice the partial root, so its top bits are zero
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign take   = rem_sh >= trial;

    always_comb begin
        rem_next  = take ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[R_W-2:0], take};
        rad_next  = {rad_in[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

>>> rtl/lpcp_div_cell.sv
// ----------------------------------------------------------------------------
// lpcp_div_cell: one quotient bit of an unsigned restoring divider
// Compares the remainder with the shifted divisor and hands all on registered.
// ----------------------------------------------------------------------------
module lpcp_div_cell #(
    parameter int N_W   = 8,
    parameter int D_W   = 8,
    parameter int Q_W   = 8,
    parameter int SHIFT = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [N_W-1:0] rem_in,
    input  logic [D_W-1:0] den_in,
    input  logic [Q_W-1:0] quo_in,
    output logic [N_W-1:0] rem_out,
    output logic [D_W-1:0] den_out,
    output logic [Q_W-1:0] quo_out
);

    localparam int CW = (N_W > D_W + SHIFT) ? N_W : D_W + SHIFT;

    logic [CW-1:0]  rem_ext;
    logic [CW-1:0]  trial;
    logic           take;
    logic [N_W-1:0] rem_next;
    logic [Q_W-1:0] quo_next;
    logic [N_W-1:0] rem_reg;
    logic [D_W-1:0] den_reg;
    logic [Q_W-1:0] quo_reg;

    assign rem_ext = CW'(rem_in);
    assign trial   = CW'(den_in) << SHIFT;
    assign take    = rem_ext >= trial;

    always_comb begin
        rem_next = take ? N_W'(rem_ext - trial) : rem_in;
        quo_next = quo_in | (Q_W'(take) << SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

>>> rtl/lidar_point_camera_projector_top.sv
// ----------------------------------------------------------------------------
// lidar_point_camera_projector_top: lidar point to camera pixel projector
// Extrinsic transform, depth by square root, intrinsic projection with
// divider chains, pixel bounds check and depth hue.
//
//   channel   ports                          content
//   input     s_tvalid s_tready s_tdata      point x, y, z (COORD_BITS each)
//   result    m_tvalid m_tready m_tdata      u, v, depth, hue
//             m_tuser                        status
//   config    cfg_valid cfg_ready            cfg_index, cfg_data
//
// one point per cycle unless stalled; NS = min(CM_W,31) + 1 cells form the
// square root chain, which followed by the hue prep and 8-cell hue divider
// sets the latency; the 17-cell u/v dividers run beside it
// stalls: the whole pipe holds while the result register is full and not taken
// reset: configuration registers take their defaults, no clearing pass
// ----------------------------------------------------------------------------
module lidar_point_camera_projector_top
    import lpcp_pkg::*;
#(
    parameter int COORD_BITS     = 20,
    parameter int COEF_FRAC_BITS = 14,
    localparam int S_TDATA_W     = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // point_x_mm, point_y_mm, point_z_mm
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // pixel_u, pixel_v, depth_mm, hue
    output logic [1:0]            m_tuser,   // status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int MAXW   = (COORD_BITS > COEF_FRAC_BITS) ? COORD_BITS : COEF_FRAC_BITS;
    localparam int PE_W   = EXT_COEF_W + COORD_BITS;
    localparam int ACC_W  = MAXW + EXT_COEF_W + 3;
    localparam int CM_W   = ACC_W - COEF_FRAC_BITS;
    localparam int SQA_W  = (CM_W < 31) ? CM_W : 31;
    localparam int SQ_W   = 2 * SQA_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int NS     = SQA_W + 1;
    localparam int PR_W   = INT_COEF_W + CM_W;
    localparam int T_W    = PR_W + 2;
    localparam int OVF_W  = T_W + UV_QUO_W;
    localparam int UV_DLY = NS - 8;
    localparam int LAT    = NS + 14;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    // configuration registers
    logic [63:0] ext_reg [3];
    logic [63:0] int_reg [3];
    logic [63:0] depth_range_reg;
    logic [31:0] image_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg[0]      <= EXT_ROW_X_RST;
            ext_reg[1]      <= EXT_ROW_Y_RST;
            ext_reg[2]      <= EXT_ROW_Z_RST;
            int_reg[0]      <= INT_ROW_U_RST;
            int_reg[1]      <= INT_ROW_V_RST;
            int_reg[2]      <= INT_ROW_W_RST;
            depth_range_reg <= DEPTH_RANGE_RST;
            image_size_reg  <= IMAGE_SIZE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_EXT_ROW_X:   ext_reg[0]      <= cfg_data;
                CFG_EXT_ROW_Y:   ext_reg[1]      <= cfg_data;
                CFG_EXT_ROW_Z:   ext_reg[2]      <= cfg_data;
                CFG_INT_ROW_U:   int_reg[0]      <= cfg_data;
                CFG_INT_ROW_V:   int_reg[1]      <= cfg_data;
                CFG_INT_ROW_W:   int_reg[2]      <= cfg_data;
                CFG_DEPTH_RANGE: depth_range_reg <= cfg_data;
                CFG_IMAGE_SIZE:  image_size_reg  <= cfg_data[31:0];
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // pipe control
    logic           pipe_en;
    logic [LAT-1:0] valid_reg;
    logic           m_tvalid_reg;

    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            valid_reg    <= {valid_reg[LAT-2:0], s_tvalid && s_tready};
            m_tvalid_reg <= valid_reg[LAT-1];
        end
    end

    // coefficient fields
    logic signed [COORD_BITS-1:0] pt        [3];
    logic signed [EXT_COEF_W-1:0] ext_coef  [3][3];
    logic signed [EXT_COEF_W-1:0] ext_trans [3];
    logic signed [INT_COEF_W-1:0] int_coef  [3][3];

    for (genvar i = 0; i < 3; i++) begin : g_fields
        assign pt[i]        = s_tdata[i*COORD_BITS +: COORD_BITS];
        assign ext_trans[i] = ext_reg[i][63:48];
        for (genvar j = 0; j < 3; j++) begin : g_col
            assign ext_coef[i][j] = ext_reg[i][32-16*j +: EXT_COEF_W];
            assign int_coef[i][j] = int_reg[i][42-21*j +: INT_COEF_W];
        end
    end

    // stage 1: extrinsic products
    logic signed [PE_W-1:0] pe_reg [3][3];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    pe_reg[i][j] <= ext_coef[i][j] * pt[j];
                end
            end
        end
    end

    // stage 2: exact camera coordinates, rounding to whole mm
    logic signed [ACC_W-1:0] acc     [3];
    logic signed [ACC_W-1:0] acc_rnd [3];
    logic signed [CM_W-1:0]  cm_next [3];
    logic signed [CM_W-1:0]  cm_reg  [3];
    logic                    behind_next;
    logic                    behind_s2_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = (ACC_W'(ext_trans[i]) <<< COEF_FRAC_BITS) + ACC_W'(pe_reg[i][0])
                   + ACC_W'(pe_reg[i][1]) + ACC_W'(pe_reg[i][2]);
            acc_rnd[i] = acc[i] + ROUND_HALF;
            cm_next[i] = CM_W'(acc_rnd[i] >>> COEF_FRAC_BITS);
        end
        behind_next = acc[2][ACC_W-1] || (acc[2] == '0);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cm_reg        <= cm_next;
            behind_s2_reg <= behind_next;
        end
    end

    // stage 3: squares and intrinsic products
    logic [CM_W-1:0]        cm_abs   [3];
    logic [SQA_W-1:0]       sqa      [3];
    logic [SQ_W-1:0]        sq_next  [3];
    logic [SQ_W-1:0]        sq_reg   [3];
    logic                   big_next;
    logic                   big_s3_reg;
    logic                   behind_s3_reg;
    logic signed [PR_W-1:0] pr_reg   [3][3];

    always_comb begin
        big_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            cm_abs[i]  = cm_reg[i][CM_W-1] ? CM_W'(-cm_reg[i]) : CM_W'(cm_reg[i]);
            sqa[i]     = SQA_W'(cm_abs[i]);
            sq_next[i] = sqa[i] * sqa[i];
            if (64'(cm_abs[i]) >= 64'h8000_0000) begin
                big_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sq_reg        <= sq_next;
            big_s3_reg    <= big_next;
            behind_s3_reg <= behind_s2_reg;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    pr_reg[i][j] <= int_coef[i][j] * cm_reg[j];
                end
            end
        end
    end

    // stage 4: radicand and projection terms
    logic [SUM_W-1:0]      rad_reg;
    logic signed [T_W-1:0] t_reg [3];
    logic                  big_s4_reg;
    logic                  behind_s4_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rad_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            for (int i = 0; i < 3; i++) begin
                t_reg[i] <= T_W'(pr_reg[i][0]) + T_W'(pr_reg[i][1]) + T_W'(pr_reg[i][2]);
            end
            big_s4_reg    <= big_s3_reg;
            behind_s4_reg <= behind_s3_reg;
        end
    end

    // square root chain
    logic [SUM_W-1:0] sr_rad  [NS+1];
    logic [NS+2:0]    sr_rem  [NS+1];
    logic [NS-1:0]    sr_root [NS+1];
    logic             big_d;

    assign sr_rad[0]  = rad_reg;
    assign sr_rem[0]  = '0;
    assign sr_root[0] = '0;

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        lpcp_sqrt_cell #(.R_W(NS)) u_cell (
            .aclk     (aclk),
            .en       (pipe_en),
            .rad_in   (sr_rad[g]),
            .rem_in   (sr_rem[g]),
            .root_in  (sr_root[g]),
            .rad_out  (sr_rad[g+1]),
            .rem_out  (sr_rem[g+1]),
            .root_out (sr_root[g+1])
        );
    end

    lpcp_delay #(.W(1), .DEPTH(NS)) u_big_dly (
        .aclk (aclk),
        .en   (pipe_en),
        .d    (big_s4_reg),
        .q    (big_d)
    );

    // u/v prep: magnitudes, signs, overflow beyond the quotient range
    logic [T_W-1:0] t_abs [3];
    uv_flags_t      uvf_next;
    uv_flags_t      uvf_reg;
    logic [T_W-1:0] num_u_reg;
    logic [T_W-1:0] num_v_reg;
    logic [T_W-1:0] den_uv_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t_abs[i] = t_reg[i][T_W-1] ? T_W'(-t_reg[i]) : T_W'(t_reg[i]);
        end
        uvf_next.behind     = behind_s4_reg;
        uvf_next.zero_scale = (t_abs[2] == '0);
        uvf_next.neg_u      = t_reg[0][T_W-1] ^ t_reg[2][T_W-1];
        uvf_next.neg_v      = t_reg[1][T_W-1] ^ t_reg[2][T_W-1];
        uvf_next.ovf_u      = OVF_W'(t_abs[0]) >= (OVF_W'(t_abs[2]) << UV_QUO_W);
        uvf_next.ovf_v      = OVF_W'(t_abs[1]) >= (OVF_W'(t_abs[2]) << UV_QUO_W);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            uvf_reg    <= uvf_next;
            num_u_reg  <= t_abs[0];
            num_v_reg  <= t_abs[1];
            den_uv_reg <= t_abs[2];
        end
    end

    // u and v divider chains
    logic [T_W-1:0]      du_rem [UV_QUO_W+1];
    logic [T_W-1:0]      du_den [UV_QUO_W+1];
    logic [UV_QUO_W-1:0] du_quo [UV_QUO_W+1];
    logic [T_W-1:0]      dv_rem [UV_QUO_W+1];
    logic [T_W-1:0]      dv_den [UV_QUO_W+1];
    logic [UV_QUO_W-1:0] dv_quo [UV_QUO_W+1];
    uv_flags_t           uvf_d;
    uv_res_t             uv_mid;
    uv_res_t             uv_fin;

    assign du_rem[0] = num_u_reg;
    assign du_den[0] = den_uv_reg;
    assign du_quo[0] = '0;
    assign dv_rem[0] = num_v_reg;
    assign dv_den[0] = den_uv_reg;
    assign dv_quo[0] = '0;

    for (genvar g = 0; g < UV_QUO_W; g++) begin : g_div_uv
        lpcp_div_cell #(
            .N_W(T_W), .D_W(T_W), .Q_W(UV_QUO_W), .SHIFT(UV_QUO_W - 1 - g)
        ) u_cell_u (
            .aclk    (aclk),
            .en      (pipe_en),
            .rem_in  (du_rem[g]),
            .den_in  (du_den[g]),
            .quo_in  (du_quo[g]),
            .rem_out (du_rem[g+1]),
            .den_out (du_den[g+1]),
            .quo_out (du_quo[g+1])
        );
        lpcp_div_cell #(
            .N_W(T_W), .D_W(T_W), .Q_W(UV_QUO_W), .SHIFT(UV_QUO_W - 1 - g)
        ) u_cell_v (
            .aclk    (aclk),
            .en      (pipe_en),
            .rem_in  (dv_rem[g]),
            .den_in  (dv_den[g]),
            .quo_in  (dv_quo[g]),
            .rem_out (dv_rem[g+1]),
            .den_out (dv_den[g+1]),
            .quo_out (dv_quo[g+1])
        );
    end

    lpcp_delay #(.W($bits(uv_flags_t)), .DEPTH(UV_QUO_W)) u_uvf_dly (
        .aclk (aclk),
        .en   (pipe_en),
        .d    (uvf_reg),
        .q    (uvf_d)
    );

    assign uv_mid.flags = uvf_d;
    assign uv_mid.mag_u = du_quo[UV_QUO_W];
    assign uv_mid.mag_v = dv_quo[UV_QUO_W];

    // line the u/v results up with the end of the hue divider
    lpcp_delay #(.W($bits(uv_res_t)), .DEPTH(UV_DLY)) u_uv_dly (
        .aclk (aclk),
        .en   (pipe_en),
        .d    (uv_mid),
        .q    (uv_fin)
    );

    // hue prep a: depth, clamp, span
    logic [DEFF_W-1:0] deff;
    logic [31:0]       dmin;
    logic [31:0]       dmax;
    logic [31:0]       dclamp;
    logic [31:0]       hue_diff_next;
    logic [31:0]       hue_diff_reg;
    logic [31:0]       hue_span_reg;
    hue_side_t         side_next;
    hue_side_t         side_reg;
    hue_side_t         side_fin;

    assign dmin = depth_range_reg[31:0];
    assign dmax = depth_range_reg[63:32];

    always_comb begin
        deff = big_d ? DEFF_BIG : DEFF_W'(sr_root[NS]);
        if (deff > DEFF_W'(dmax)) begin
            dclamp = dmax;
        end else if (deff < DEFF_W'(dmin)) begin
            dclamp = dmin;
        end else begin
            dclamp = deff[31:0];
        end
        hue_diff_next        = dmax - dclamp;
        side_next.depth      = (deff > DEFF_W'(DEPTH_MAX)) ? DEPTH_MAX : deff[DEPTH_W-1:0];
        side_next.degenerate = !(dmax > dmin);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            hue_diff_reg <= hue_diff_next;
            hue_span_reg <= dmax - dmin;
            side_reg     <= side_next;
        end
    end

    // hue prep b: 480 * diff + span over 2 * span gives the rounded 240 scale
    logic [HUE_NUM_W-1:0] hue_num_reg;
    logic [HUE_DEN_W-1:0] hue_den_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            hue_num_reg <= (HUE_NUM_W'(hue_diff_reg) << 9) - (HUE_NUM_W'(hue_diff_reg) << 5)
                         + HUE_NUM_W'(hue_span_reg);
            hue_den_reg <= {hue_span_reg, 1'b0};
        end
    end

    lpcp_delay #(.W($bits(hue_side_t)), .DEPTH(HUE_W + 1)) u_side_dly (
        .aclk (aclk),
        .en   (pipe_en),
        .d    (side_reg),
        .q    (side_fin)
    );

    // hue divider chain
    logic [HUE_NUM_W-1:0] dh_rem [HUE_W+1];
    logic [HUE_DEN_W-1:0] dh_den [HUE_W+1];
    logic [HUE_W-1:0]     dh_quo [HUE_W+1];

    assign dh_rem[0] = hue_num_reg;
    assign dh_den[0] = hue_den_reg;
    assign dh_quo[0] = '0;

    for (genvar g = 0; g < HUE_W; g++) begin : g_div_hue
        lpcp_div_cell #(
            .N_W(HUE_NUM_W), .D_W(HUE_DEN_W), .Q_W(HUE_W), .SHIFT(HUE_W - 1 - g)
        ) u_cell (
            .aclk    (aclk),
            .en      (pipe_en),
            .rem_in  (dh_rem[g]),
            .den_in  (dh_den[g]),
            .quo_in  (dh_quo[g]),
            .rem_out (dh_rem[g+1]),
            .den_out (dh_den[g+1]),
            .quo_out (dh_quo[g+1])
        );
    end

    // result assembly
    function automatic logic [PIX_W-1:0] sat_pix(
        input logic [UV_QUO_W-1:0] mag,
        input logic                neg,
        input logic                ovf
    );
        logic [PIX_W-1:0] r;
        if (ovf) begin
            r = neg ? PIX_MIN : PIX_MAX;
        end else if (neg) begin
            r = (mag > UV_QUO_W'(32768)) ? PIX_MIN : PIX_W'(UV_QUO_W'(0) - mag);
        end else begin
            r = (mag > UV_QUO_W'(32767)) ? PIX_MAX : mag[PIX_W-1:0];
        end
        return r;
    endfunction

    function automatic logic in_range(
        input logic [UV_QUO_W-1:0] mag,
        input logic                neg,
        input logic                ovf,
        input logic [15:0]         limit
    );
        return !ovf && (!neg || (mag == '0)) && (mag < UV_QUO_W'(limit));
    endfunction

    status_t            out_status;
    logic [PIX_W-1:0]   out_u;
    logic [PIX_W-1:0]   out_v;
    logic [DEPTH_W-1:0] out_depth;
    logic [HUE_W-1:0]   out_hue;
    logic               in_u;
    logic               in_v;

    always_comb begin
        in_u = in_range(uv_fin.mag_u, uv_fin.flags.neg_u, uv_fin.flags.ovf_u,
                        image_size_reg[15:0]);
        in_v = in_range(uv_fin.mag_v, uv_fin.flags.neg_v, uv_fin.flags.ovf_v,
                        image_size_reg[31:16]);
        out_status = STATUS_OUTSIDE;
        out_u      = '0;
        out_v      = '0;
        out_depth  = '0;
        out_hue    = '0;
        if (uv_fin.flags.behind) begin
            out_status = STATUS_BEHIND;
        end else begin
            out_depth = side_fin.depth;
            out_hue   = side_fin.degenerate ? '0 : dh_quo[HUE_W];
            if (uv_fin.flags.zero_scale) begin
                out_status = STATUS_ZERO_SCALE;
            end else begin
                out_u      = sat_pix(uv_fin.mag_u, uv_fin.flags.neg_u, uv_fin.flags.ovf_u);
                out_v      = sat_pix(uv_fin.mag_v, uv_fin.flags.neg_v, uv_fin.flags.ovf_v);
                out_status = (in_u && in_v) ? STATUS_INSIDE : STATUS_OUTSIDE;
            end
        end
    end

    logic [M_TDATA_W-1:0] m_tdata_reg;
    status_t              m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_tdata_reg <= M_TDATA_W'({out_hue, out_depth, out_v, out_u});
            m_tuser_reg <= out_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    logic [PIX_W-1:0] chk_u;
    logic [PIX_W-1:0] chk_v;
    logic [HUE_W-1:0] chk_hue;

    assign chk_u   = m_tdata_reg[PIX_W-1:0];
    assign chk_v   = m_tdata_reg[2*PIX_W-1:PIX_W];
    assign chk_hue = m_tdata_reg[2*PIX_W+DEPTH_W +: HUE_W];

    a_behind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_tuser_reg == STATUS_BEHIND) |-> (m_tdata_reg == '0))
        else $error("behind-camera result carries data");

    a_zero_scale_pix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_tuser_reg == STATUS_ZERO_SCALE) |-> (chk_u == '0) && (chk_v == '0))
        else $error("zero-scale result carries a pixel");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (chk_hue <= HUE_W'(HUE_MAX)))
        else $error("hue above full scale");

    a_inside_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_tuser_reg == STATUS_INSIDE) |->
            (chk_u < image_size_reg[15:0]) && (chk_v < image_size_reg[31:16]))
        else $error("inside pixel out of image bounds");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(valid_reg))
        else $error("pipe moved while stalled");

endmodule
